>>> src/xor_ramp_block_descrambler_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the XOR ramp block descrambler
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef XOR_RAMP_BLOCK_DESCRAMBLER_UNIT_ASSERT_SVH
`define XOR_RAMP_BLOCK_DESCRAMBLER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// condition holds in every cycle out of reset
`define XRBD_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("xrbd assertion failed");

// consequent holds in the same cycle as the antecedent
`define XRBD_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("xrbd assertion failed");

// consequent holds in the cycle after the antecedent
`define XRBD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("xrbd assertion failed");

`else

`define XRBD_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define XRBD_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define XRBD_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> src/xrbd_pkg.sv
// ----------------------------------------------------------------------------
// xrbd_pkg
// Shared widths, register codes, reset values and types of the descrambler.
// ----------------------------------------------------------------------------
package xrbd_pkg;

   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 32;
   localparam int BLK_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // default depth of the front-to-back queue
   localparam int QUEUE_DEPTH = 4;

   // modulo unit: one quotient bit per cycle
   localparam int DIV_STEPS = LEN_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_KEY   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_STEP      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_LENGTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DECRYPT_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STREAM_LENGTH = 3'd4;

   // register reset values
   localparam logic [BYTE_W-1:0] RST_INITIAL_KEY   = 8'd0;
   localparam logic [BYTE_W-1:0] RST_KEY_STEP      = 8'd0;
   localparam logic [BLK_W-1:0]  RST_BLOCK_LENGTH  = 16'd256;
   localparam logic [LEN_W-1:0]  RST_DECRYPT_LIMIT = 32'hFFFF_FFFF;
   localparam logic [LEN_W-1:0]  RST_STREAM_LENGTH = 32'd0;

   typedef struct packed {
      logic [BYTE_W-1:0] initial_key;
      logic [BYTE_W-1:0] key_step;
      logic [BLK_W-1:0]  block_length;
      logic [LEN_W-1:0]  decrypt_limit;
      logic [LEN_W-1:0]  stream_length;
   } csr_type;

   // one classified byte on its way from front to back
   typedef struct packed {
      logic [BYTE_W-1:0] cipher_byte;
      logic              stream_start;
      logic [LEN_W-1:0]  scrambled_length;   // valid with stream_start only
   } qentry_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_DIV,
      FR_FINISH
   } front_state_type;

endpackage

>>> src/xrbd_front.sv
// ----------------------------------------------------------------------------
// xrbd_front
// Accepts input bytes and classifies them. A start byte is held while the
// scrambled length is worked out by a bit-serial modulo unit.
// ----------------------------------------------------------------------------
module xrbd_front (
   input  logic                        clock,
   input  logic                        reset,
   input  xrbd_pkg::csr_type           csr,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [xrbd_pkg::BYTE_W-1:0] req_cipher_byte,
   input  logic                        req_stream_start,
   input  logic                        q_full,
   output logic                        q_push,
   output xrbd_pkg::qentry_type        q_data
);

   xrbd_pkg::front_state_type state_ff, state_in;

   logic [xrbd_pkg::BYTE_W-1:0]    byte_ff;
   logic [xrbd_pkg::LEN_W-1:0]     dividend_ff;
   logic [xrbd_pkg::BLK_W-1:0]     rem_ff, rem_in;
   logic [xrbd_pkg::DIV_CNT_W-1:0] cnt_ff;

   logic                        accept_start;
   logic [xrbd_pkg::BLK_W:0]    trial;
   logic [xrbd_pkg::BLK_W:0]    tail;
   logic [xrbd_pkg::LEN_W-1:0]  scr_len;

   assign accept_start = req_push && !q_full && req_stream_start;

   // restoring modulo step
   always_comb begin
      trial = {rem_ff, dividend_ff[xrbd_pkg::LEN_W-1]};
      if (trial >= {1'b0, csr.block_length}) begin
         rem_in = xrbd_pkg::BLK_W'(trial - {1'b0, csr.block_length});
      end else begin
         rem_in = trial[xrbd_pkg::BLK_W-1:0];
      end
   end

   // tail and scrambled length from the remainder
   always_comb begin
      if (rem_ff >= (csr.block_length >> 2)) begin
         tail = '0;
      end else begin
         tail = {1'b0, rem_ff};
      end
      tail = tail + {{xrbd_pkg::BLK_W{1'b0}}, csr.stream_length[0]};
      if (csr.block_length == '0) begin
         scr_len = '0;
      end else if (xrbd_pkg::LEN_W'(tail) > csr.stream_length) begin
         scr_len = '0;
      end else begin
         scr_len = csr.stream_length - xrbd_pkg::LEN_W'(tail);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         xrbd_pkg::FR_IDLE: begin
            if (accept_start) state_in = xrbd_pkg::FR_DIV;
         end
         xrbd_pkg::FR_DIV: begin
            if (cnt_ff == xrbd_pkg::DIV_CNT_W'(xrbd_pkg::DIV_STEPS - 1)) begin
               state_in = xrbd_pkg::FR_FINISH;
            end
         end
         xrbd_pkg::FR_FINISH: begin
            if (!q_full) state_in = xrbd_pkg::FR_IDLE;
         end
         default: state_in = xrbd_pkg::FR_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_full              = 1'b1;
      q_push                = 1'b0;
      q_data.cipher_byte      = req_cipher_byte;
      q_data.stream_start     = 1'b0;
      q_data.scrambled_length = '0;
      unique case (state_ff)
         xrbd_pkg::FR_IDLE: begin
            req_full = q_full;
            q_push   = req_push && !q_full && !req_stream_start;
         end
         xrbd_pkg::FR_DIV: begin
            req_full = 1'b1;
         end
         xrbd_pkg::FR_FINISH: begin
            q_push                  = !q_full;
            q_data.cipher_byte      = byte_ff;
            q_data.stream_start     = 1'b1;
            q_data.scrambled_length = scr_len;
         end
         default: req_full = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= xrbd_pkg::FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // modulo datapath
   always_ff @(posedge clock) begin
      if (state_ff == xrbd_pkg::FR_IDLE && accept_start) begin
         byte_ff     <= req_cipher_byte;
         dividend_ff <= csr.stream_length;
         rem_ff      <= '0;
         cnt_ff      <= '0;
      end else if (state_ff == xrbd_pkg::FR_DIV) begin
         dividend_ff <= dividend_ff << 1;
         rem_ff      <= rem_in;
         cnt_ff      <= cnt_ff + 1'b1;
      end
   end

endmodule

>>> src/xrbd_queue.sv
// ----------------------------------------------------------------------------
// xrbd_queue
// Small register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module xrbd_queue #(
   parameter int DEPTH = xrbd_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  xrbd_pkg::qentry_type push_data,
   output logic                 full,
   input  logic                 pop,
   output xrbd_pkg::qentry_type head_data,
   output logic                 empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   xrbd_pkg::qentry_type entry_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

>>> src/xrbd_back.sv
// ----------------------------------------------------------------------------
// xrbd_back
// Per-byte descrambling: block tracking, running key, output offset, and the
// result register.
// ----------------------------------------------------------------------------
module xrbd_back (
   input  logic                        clock,
   input  logic                        reset,
   input  xrbd_pkg::csr_type           csr,
   input  logic                        q_empty,
   input  xrbd_pkg::qentry_type        q_data,
   output logic                        q_pop,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [xrbd_pkg::BYTE_W-1:0] rsp_plain_byte,
   output logic [xrbd_pkg::LEN_W-1:0]  rsp_out_offset,
   output logic                        rsp_was_decrypted,
   output logic                        rsp_end_of_stream
);

   localparam int BW = xrbd_pkg::BLK_W;
   localparam int LW = xrbd_pkg::LEN_W;

   // stream state
   logic [xrbd_pkg::BYTE_W-1:0] key_ff, key_in;
   logic [LW-1:0] pos_ff, pos_in;
   logic [LW-1:0] base_ff, base_in;
   logic [LW-1:0] scr_ff, scr_in;
   logic [LW-1:0] rem_ff, rem_in;     // scrambled length minus position
   logic [BW-1:0] size_ff, size_in;
   logic [BW-1:0] half_ff, half_in;
   logic [BW-1:0] idx_ff, idx_in;
   logic          active_ff, active_in;
   logic          rsp_valid_ff;

   // result register
   logic [xrbd_pkg::BYTE_W-1:0] plain_ff, plain_in;
   logic [LW-1:0]               offset_ff, offset_in;
   logic                        dec_ff, dec_in;
   logic                        eos_ff, eos_in;

   logic                        take, start;
   logic [xrbd_pkg::BYTE_W-1:0] key_e;
   logic [LW-1:0] pos_e, base_e, scr_e, rem_e;
   logic [BW-1:0] size_e, half_e, idx_e;
   logic          act_e, pos_lt, blk_start, kill, new_blk;
   logic [BW-1:0] size_new, half_new;
   logic [BW:0]   idx2, dest, idx_inc;

   assign take      = !q_empty && (!rsp_valid_ff || rsp_pop);
   assign q_pop     = take;
   assign start     = q_data.stream_start;
   assign rsp_empty = !rsp_valid_ff;

   // state as seen by this byte: a start byte restarts everything
   always_comb begin
      key_e  = start ? csr.initial_key : key_ff;
      pos_e  = start ? '0 : pos_ff;
      base_e = start ? '0 : base_ff;
      size_e = start ? '0 : size_ff;
      half_e = start ? '0 : half_ff;
      idx_e  = start ? '0 : idx_ff;
      scr_e  = start ? q_data.scrambled_length : scr_ff;
      rem_e  = start ? q_data.scrambled_length : rem_ff;
      act_e  = start ? 1'b1 : active_ff;
   end

   // block boundary handling
   always_comb begin
      pos_lt    = pos_e < scr_e;
      blk_start = act_e && pos_lt && (idx_e == '0);
      kill      = (pos_e >= csr.decrypt_limit) || (csr.block_length == '0);
      new_blk   = blk_start && !kill;
      size_new  = (rem_e < LW'(csr.block_length)) ? rem_e[BW-1:0] : csr.block_length;
      half_new  = BW'(({1'b0, size_new} + 1'b1) >> 1);
      active_in = (blk_start && kill) ? 1'b0 : act_e;
      size_in   = new_blk ? size_new : size_e;
      half_in   = new_blk ? half_new : half_e;
      base_in   = new_blk ? pos_e : base_e;
      dec_in    = active_in && pos_lt && (size_in != '0);
   end

   // destination inside the block: odd-from-end first, then even-from-end
   always_comb begin
      idx2 = {idx_e, 1'b0};
      if (idx_e < half_e) begin
         dest = {1'b0, size_e} - 1'b1 - idx2;
      end else begin
         dest = {1'b0, size_e} - 2'd2 - idx2 + {half_e, 1'b0};
      end
   end

   // result and next state
   always_comb begin
      plain_in = q_data.cipher_byte;
      key_in   = key_e;
      idx_in   = idx_e;
      idx_inc  = {1'b0, idx_e} + 1'b1;
      if (!dec_in) begin
         offset_in = pos_e;
      end else if (new_blk) begin
         offset_in = pos_e + LW'(size_new) - 1'b1;
      end else begin
         offset_in = base_e + LW'(dest[BW-1:0]);
      end
      if (dec_in) begin
         plain_in = q_data.cipher_byte ^ key_e;
         key_in   = key_e + csr.key_step;
         idx_in   = (idx_inc >= {1'b0, size_in}) ? '0 : idx_inc[BW-1:0];
      end
      eos_in = (csr.stream_length != '0) && (pos_e == csr.stream_length - 1'b1);
      pos_in = pos_e + 1'b1;
      rem_in = rem_e - 1'b1;
      scr_in = scr_e;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= '0;
         pos_ff       <= '0;
         base_ff      <= '0;
         scr_ff       <= '0;
         rem_ff       <= '0;
         size_ff      <= '0;
         half_ff      <= '0;
         idx_ff       <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            key_ff    <= key_in;
            pos_ff    <= pos_in;
            base_ff   <= base_in;
            scr_ff    <= scr_in;
            rem_ff    <= rem_in;
            size_ff   <= size_in;
            half_ff   <= half_in;
            idx_ff    <= idx_in;
            active_ff <= active_in;
         end
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (take) begin
         plain_ff  <= plain_in;
         offset_ff <= offset_in;
         dec_ff    <= dec_in;
         eos_ff    <= eos_in;
      end
   end

   assign rsp_plain_byte    = plain_ff;
   assign rsp_out_offset    = offset_ff;
   assign rsp_was_decrypted = dec_ff;
   assign rsp_end_of_stream = eos_ff;

endmodule

>>> src/xor_ramp_block_descrambler_unit.sv
// Path: an ordinary byte passes the queue entry register and then the result register.
// A start byte waits first: the scrambled length comes from a one-bit-per-cycle
// modulo of the stream length by the block length, and input is held meanwhile.
// Throughput: one byte per cycle between start bytes while results are popped.
// Reset: synchronous, active high; clears queue, counters, key and the registers
// to their reset values; no clearing pass.
// ----------------------------------------------------------------------------
// xor_ramp_block_descrambler_unit
// Top level: register file, front classifier, queue, and descrambling back.
// ----------------------------------------------------------------------------
`include "xor_ramp_block_descrambler_unit_assert.svh"

module xor_ramp_block_descrambler_unit #(
   parameter int QUEUE_DEPTH = xrbd_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration
   input  logic                            csr_write_enable,
   input  logic [xrbd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [xrbd_pkg::CSR_DATA_W-1:0] csr_wdata,
   // input bytes
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [xrbd_pkg::BYTE_W-1:0]     req_cipher_byte,
   input  logic                            req_stream_start,
   // results
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [xrbd_pkg::BYTE_W-1:0]     rsp_plain_byte,
   output logic [xrbd_pkg::LEN_W-1:0]      rsp_out_offset,
   output logic                            rsp_was_decrypted,
   output logic                            rsp_end_of_stream
);

   xrbd_pkg::csr_type    csr_ff;
   xrbd_pkg::qentry_type q_push_data, q_head_data;
   logic                 q_push, q_full, q_pop, q_empty;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.initial_key   <= xrbd_pkg::RST_INITIAL_KEY;
         csr_ff.key_step      <= xrbd_pkg::RST_KEY_STEP;
         csr_ff.block_length  <= xrbd_pkg::RST_BLOCK_LENGTH;
         csr_ff.decrypt_limit <= xrbd_pkg::RST_DECRYPT_LIMIT;
         csr_ff.stream_length <= xrbd_pkg::RST_STREAM_LENGTH;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            xrbd_pkg::CSR_INITIAL_KEY:
               csr_ff.initial_key <= csr_wdata[xrbd_pkg::BYTE_W-1:0];
            xrbd_pkg::CSR_KEY_STEP:
               csr_ff.key_step <= csr_wdata[xrbd_pkg::BYTE_W-1:0];
            xrbd_pkg::CSR_BLOCK_LENGTH:
               csr_ff.block_length <= csr_wdata[xrbd_pkg::BLK_W-1:0];
            xrbd_pkg::CSR_DECRYPT_LIMIT:
               csr_ff.decrypt_limit <= csr_wdata[xrbd_pkg::LEN_W-1:0];
            xrbd_pkg::CSR_STREAM_LENGTH:
               csr_ff.stream_length <= csr_wdata[xrbd_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   xrbd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr              (csr_ff),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_cipher_byte  (req_cipher_byte),
      .req_stream_start (req_stream_start),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_data           (q_push_data)
   );

   xrbd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .head_data (q_head_data),
      .empty     (q_empty)
   );

   xrbd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .csr               (csr_ff),
      .q_empty           (q_empty),
      .q_data            (q_head_data),
      .q_pop             (q_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_plain_byte    (rsp_plain_byte),
      .rsp_out_offset    (rsp_out_offset),
      .rsp_was_decrypted (rsp_was_decrypted),
      .rsp_end_of_stream (rsp_end_of_stream)
   );

   // front never writes a full queue, back never reads an empty one
   `XRBD_ASSERT_IMPLY(a_push_not_full, clock, reset, q_push, !q_full)
   `XRBD_ASSERT_IMPLY(a_pop_not_empty, clock, reset, q_pop, !q_empty)
   // a taken start byte holds off input while the modulo runs
   `XRBD_ASSERT_NEXT(a_start_holds_input, clock, reset,
      req_push && !req_full && req_stream_start, req_full)
   // a full queue always stalls input; while the front is idle its stall follows the queue alone
   `XRBD_ASSERT_ALWAYS(a_full_covers_queue, clock, reset, !q_full || req_full)

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: XOR ramp block descrambler testbench
// Drives cipher bytes through the push/full port with random gaps, pops
// results with random stalls, and compares every result field against an
// in-bench model of the descrambler. Registers are rewritten between phases,
// including mid-stream, to cover their live use.
// ----------------------------------------------------------------------------
module tb_top;
   import xrbd_pkg::*;

   localparam int STALL_LIMIT  = 3000;
   localparam int RANDOM_BYTES = 1350;

   // one expected result transaction
   typedef struct {
      logic [BYTE_W-1:0] plain_byte;
      logic [LEN_W-1:0]  out_offset;
      logic              was_decrypted;
      logic              end_of_stream;
   } plain_rec_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_push;
   logic                  req_full;
   logic [BYTE_W-1:0]     req_cipher_byte;
   logic                  req_stream_start;
   logic                  rsp_empty;
   logic                  rsp_pop;
   logic [BYTE_W-1:0]     rsp_plain_byte;
   logic [LEN_W-1:0]      rsp_out_offset;
   logic                  rsp_was_decrypted;
   logic                  rsp_end_of_stream;

   // model copy of the registers and the descrambler state
   csr_type           regs;
   logic [BYTE_W-1:0] run_key;
   logic [LEN_W-1:0]  byte_pos;
   logic [LEN_W-1:0]  blk_base;
   logic [BLK_W-1:0]  blk_size;
   logic [BLK_W-1:0]  blk_idx;
   logic [LEN_W-1:0]  scr_len;
   logic              dec_on;

   plain_rec_type pending_plain[$];
   int         mismatches = 0;
   int         bytes_sent = 0;
   int         pop_hold = 0;
   int         idle_cycles = 0;
   bit         calm = 1'b0;

   xor_ramp_block_descrambler_unit dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_cipher_byte   (req_cipher_byte),
      .req_stream_start  (req_stream_start),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_plain_byte    (rsp_plain_byte),
      .rsp_out_offset    (rsp_out_offset),
      .rsp_was_decrypted (rsp_was_decrypted),
      .rsp_end_of_stream (rsp_end_of_stream)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------------
   // Model
   // ------------------------------------------------------------------------

   // leading bytes of a stream that get descrambled
   function automatic logic [LEN_W-1:0] scrambled_span(logic [LEN_W-1:0] len,
                                                       logic [BLK_W-1:0] blen);
      logic [LEN_W-1:0] tail;
      if (blen == 0) return '0;
      tail = len % blen;
      if (tail >= (blen >> 2)) tail = '0;
      tail = tail + len[0];
      return (tail > len) ? '0 : len - tail;
   endfunction

   // advance the model by one cipher byte and return its result
   function automatic plain_rec_type descramble_byte(logic [BYTE_W-1:0] cb, logic st);
      plain_rec_type    r;
      logic [LEN_W-1:0] pos, rem, size32, idx32, half, dest;
      if (st) begin
         run_key  = regs.initial_key;
         byte_pos = '0;
         blk_base = '0;
         blk_size = '0;
         blk_idx  = '0;
         scr_len  = scrambled_span(regs.stream_length, regs.block_length);
         dec_on   = 1'b1;
      end
      pos             = byte_pos;
      r.plain_byte    = cb;
      r.out_offset    = pos;
      r.was_decrypted = 1'b0;
      // new block: either it starts at or past the limit (or the block length is zero) or it gets its size
      if (dec_on && pos < scr_len && blk_idx == 0) begin
         if (pos >= regs.decrypt_limit || regs.block_length == 0) begin
            dec_on = 1'b0;
         end else begin
            rem      = scr_len - pos;
            blk_base = pos;
            blk_size = (rem < regs.block_length) ? rem[BLK_W-1:0] : regs.block_length;
         end
      end
      // xor with the ramp key and interleave from the block end
      if (dec_on && pos < scr_len && blk_size != 0) begin
         size32 = blk_size;
         idx32  = blk_idx;
         half   = (size32 + 1) >> 1;
         if (idx32 < half) dest = size32 - 1 - 2 * idx32;
         else              dest = size32 - 2 - 2 * (idx32 - half);
         r.plain_byte    = cb ^ run_key;
         r.out_offset    = blk_base + dest;
         r.was_decrypted = 1'b1;
         run_key         = run_key + regs.key_step;
         blk_idx         = blk_idx + 1;
         if (blk_idx >= blk_size) blk_idx = '0;
      end
      r.end_of_stream = (regs.stream_length != 0) && (pos == regs.stream_length - 1);
      byte_pos = pos + 1;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // mostly short gaps, now and then a long one; none in calm phases
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic csr_type make_cfg(logic [7:0] k, logic [7:0] s, logic [15:0] b,
                                        logic [31:0] lim, logic [31:0] len);
      csr_type c;
      c.initial_key   = k;
      c.key_step      = s;
      c.block_length  = b;
      c.decrypt_limit = lim;
      c.stream_length = len;
      return c;
   endfunction

   function automatic csr_type random_cfg();
      csr_type c;
      int      r;
      c.initial_key = $urandom_range(0, 255);
      r = $urandom_range(0, 9);
      c.key_step = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(0, 255));
      r = $urandom_range(0, 19);
      if (r == 0)      c.block_length = 16'd0;
      else if (r == 1) c.block_length = 16'hFFFF;
      else if (r == 2) c.block_length = 16'd1;
      else if (r < 5)  c.block_length = 16'($urandom);
      else             c.block_length = 16'($urandom_range(2, 24));
      r = $urandom_range(0, 9);
      if (r < 4)       c.decrypt_limit = 32'hFFFF_FFFF;
      else if (r == 4) c.decrypt_limit = 32'd0;
      else if (r == 5) c.decrypt_limit = $urandom;
      else             c.decrypt_limit = $urandom_range(0, 80);
      r = $urandom_range(0, 19);
      if (r == 0)      c.stream_length = 32'd0;
      else if (r == 1) c.stream_length = 32'hFFFF_FFFF;
      else if (r == 2) c.stream_length = $urandom;
      else             c.stream_length = $urandom_range(1, 72);
      return c;
   endfunction

   // one register write; the enable is lowered by the caller
   task automatic csr_put(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= val;
      case (idx)
         CSR_INITIAL_KEY:   regs.initial_key   = val[BYTE_W-1:0];
         CSR_KEY_STEP:      regs.key_step      = val[BYTE_W-1:0];
         CSR_BLOCK_LENGTH:  regs.block_length  = val[BLK_W-1:0];
         CSR_DECRYPT_LIMIT: regs.decrypt_limit = val;
         CSR_STREAM_LENGTH: regs.stream_length = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic load_registers(csr_type c);
      csr_put(CSR_INITIAL_KEY, CSR_DATA_W'(c.initial_key));
      csr_put(CSR_KEY_STEP, CSR_DATA_W'(c.key_step));
      csr_put(CSR_BLOCK_LENGTH, CSR_DATA_W'(c.block_length));
      csr_put(CSR_DECRYPT_LIMIT, c.decrypt_limit);
      csr_put(CSR_STREAM_LENGTH, c.stream_length);
      csr_write_enable <= 1'b0;
   endtask

   // push one byte; push stays high on return so back-to-back sends work
   task automatic send_byte(logic [BYTE_W-1:0] cb, logic st);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push         <= 1'b1;
      req_cipher_byte  <= cb;
      req_stream_start <= st;
      do @(posedge clock); while (req_full);
      pending_plain.push_back(descramble_byte(cb, st));
      bytes_sent++;
   endtask

   // stop pushing and wait until every result is back
   task automatic settle();
      req_push <= 1'b0;
      while (pending_plain.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // start byte then n-1 bytes; optional stray restarts and a register
   // rewrite at byte split_at
   task automatic send_stream(int n, bit noisy, int split_at);
      logic st;
      for (int i = 0; i < n; i++) begin
         if (i == split_at && i != 0) begin
            settle();
            load_registers(random_cfg());
         end
         st = (i == 0) || (noisy && $urandom_range(0, 39) == 0);
         send_byte(8'($urandom_range(0, 255)), st);
      end
   endtask

   function automatic int pick_count(logic [LEN_W-1:0] len);
      int r;
      if (len == 0 || len > 100) return $urandom_range(1, 60);
      r = $urandom_range(0, 99);
      if (r < 70) return int'(len) + $urandom_range(0, 2);
      if (r < 85) return $urandom_range(1, int'(len));
      return int'(len) + $urandom_range(3, 10);
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // bytes before any stream start pass raw at plain offsets
   task automatic test_raw_before_start();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h5A, 1'b0);
      settle();
   endtask

   task automatic test_directed_cases();
      // unit blocks, key and step at their top value
      load_registers(make_cfg(8'hFF, 8'hFF, 16'd1, 32'hFFFF_FFFF, 32'd2));
      send_stream(2, 1'b0, -1);
      settle();
      // three blocks, the last one short and past the limit, one byte beyond
      load_registers(make_cfg(8'h3C, 8'h11, 16'd4, 32'd8, 32'd11));
      send_stream(12, 1'b0, -1);
      settle();
      // zero block length: whole stream raw
      load_registers(make_cfg(8'h80, 8'h01, 16'd0, 32'hFFFF_FFFF, 32'd2));
      send_stream(2, 1'b0, -1);
      settle();
      // tail longer than the stream
      load_registers(make_cfg(8'h00, 8'h00, 16'hFFFF, 32'hFFFF_FFFF, 32'd3));
      send_stream(3, 1'b0, -1);
      settle();
      // limit at zero with the longest stream
      load_registers(make_cfg(8'hA5, 8'h07, 16'd2, 32'd0, 32'hFFFF_FFFF));
      send_stream(2, 1'b0, -1);
      settle();
   endtask

   // registers rewritten in the middle of a stream when the split point falls inside it
   task automatic test_live_registers();
      csr_type c;
      int      n;
      for (int s = 0; s < 8; s++) begin
         c = random_cfg();
         load_registers(c);
         n = pick_count(c.stream_length);
         send_stream(n, 1'b0, $urandom_range(1, n));
         settle();
      end
   endtask

   task automatic test_random_streams();
      csr_type c;
      int      n;
      while (bytes_sent < RANDOM_BYTES) begin
         calm = ($urandom_range(0, 4) == 0);
         c = random_cfg();
         load_registers(c);
         n = pick_count(c.stream_length);
         send_stream(n, ($urandom_range(0, 3) == 0),
                     ($urandom_range(0, 5) == 0) ? $urandom_range(1, n) : -1);
         settle();
      end
      calm = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Result checker and pop pacing
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      plain_rec_type e;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_plain.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result transaction, offset %0h", $time,
                     rsp_out_offset);
         end else begin
            e = pending_plain.pop_front();
            if (rsp_plain_byte !== e.plain_byte) begin
               mismatches++;
               $display("%0t: plain_byte expected %0h actual %0h", $time,
                        e.plain_byte, rsp_plain_byte);
            end
            if (rsp_out_offset !== e.out_offset) begin
               mismatches++;
               $display("%0t: out_offset expected %0h actual %0h", $time,
                        e.out_offset, rsp_out_offset);
            end
            if (rsp_was_decrypted !== e.was_decrypted) begin
               mismatches++;
               $display("%0t: was_decrypted expected %0b actual %0b", $time,
                        e.was_decrypted, rsp_was_decrypted);
            end
            if (rsp_end_of_stream !== e.end_of_stream) begin
               mismatches++;
               $display("%0t: end_of_stream expected %0b actual %0b", $time,
                        e.end_of_stream, rsp_end_of_stream);
            end
         end
      end
      if (pop_hold > 0) begin
         rsp_pop <= 1'b0;
         pop_hold--;
      end else begin
         rsp_pop <= 1'b1;
         if ($urandom_range(0, 3) == 0) pop_hold = pick_gap();
      end
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_wdata        <= '0;
      req_push         <= 1'b0;
      req_cipher_byte  <= '0;
      req_stream_start <= 1'b0;
      rsp_pop          <= 1'b0;
      regs     = make_cfg(RST_INITIAL_KEY, RST_KEY_STEP, RST_BLOCK_LENGTH,
                          RST_DECRYPT_LIMIT, RST_STREAM_LENGTH);
      run_key  = '0;
      byte_pos = '0;
      blk_base = '0;
      blk_size = '0;
      blk_idx  = '0;
      scr_len  = '0;
      dec_on   = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_raw_before_start();
      test_directed_cases();
      test_live_registers();
      test_random_streams();

      settle();
      repeat (8) @(posedge clock);
      if (pending_plain.size() != 0) begin
         mismatches++;
         $display("%0t: %0d expected results never arrived", $time,
                  pending_plain.size());
      end
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
